[rtl/traffic_matrix_top_n_assert.svh]
// Assertion macros for the traffic matrix block.
`ifndef TRAFFIC_MATRIX_TOP_N_ASSERT_SVH
`define TRAFFIC_MATRIX_TOP_N_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define TMT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define TMT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) ante |=> cons) else $error(msg);
`else
`define TMT_ASSERT(name, prop, msg)
`define TMT_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

[rtl/tmt_pkg.sv]
// Shared constants, types and helpers of the traffic matrix block.
package tmt_pkg;

    localparam int SLOT_COUNT_DEF  = 64;
    localparam int TOP_ENTRIES_DEF = 20;
    localparam int COUNT_BITS_DEF  = 32;

    localparam int SLOT_FIELD_W = 6;
    localparam int RANK_W       = 5;
    localparam int SUM_W        = 32;
    localparam int CMD_W        = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_COUNT  = 2'd0,
        CMD_REPORT = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic clear;
        logic insert;
        logic shift;
    } rk_ctrl_t;

    function automatic logic [SUM_W-1:0] sat32(input logic [63:0] v);
        sat32 = (|v[63:SUM_W]) ? {SUM_W{1'b1}} : v[SUM_W-1:0];
    endfunction

endpackage

[rtl/tmt_ranker.sv]
// Ranked top-N list with insertion compare unit and running grand total.
module tmt_ranker import tmt_pkg::*; #(
    parameter int TOP_ENTRIES = TOP_ENTRIES_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int SLOT_W      = 6,
    parameter int FILL_W      = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rk_ctrl_t              ctrl,
    input  logic [SLOT_W-1:0]     cell_src,
    input  logic [SLOT_W-1:0]     cell_dst,
    input  logic [COUNT_BITS-1:0] cell_cnt,
    output logic [SLOT_W-1:0]     head_src,
    output logic [SLOT_W-1:0]     head_dst,
    output logic [COUNT_BITS-1:0] head_cnt,
    output logic [FILL_W-1:0]     fill,
    output logic [SUM_W-1:0]      total
);

    logic [SLOT_W-1:0]     src_reg [TOP_ENTRIES];
    logic [SLOT_W-1:0]     dst_reg [TOP_ENTRIES];
    logic [COUNT_BITS-1:0] cnt_reg [TOP_ENTRIES];
    logic [FILL_W-1:0]     fill_reg;
    logic [SUM_W-1:0]      total_reg;
    logic [TOP_ENTRIES-1:0] gt;
    logic [SUM_W:0]        sum;

    always_comb begin
        for (int k = 0; k < TOP_ENTRIES; k++) begin
            gt[k] = cell_cnt > cnt_reg[k];
        end
        sum = {1'b0, total_reg} + {1'b0, sat32(64'(cell_cnt))};
    end

    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            for (int k = 0; k < TOP_ENTRIES; k++) begin
                cnt_reg[k] <= '0;
                src_reg[k] <= '0;
                dst_reg[k] <= '0;
            end
        end else if (ctrl.insert) begin
            // list is non-increasing, so the entries below the new cell form a suffix
            for (int k = 0; k < TOP_ENTRIES; k++) begin
                if (gt[k]) begin
                    if (k == 0 || !gt[(k == 0) ? 0 : k-1]) begin
                        cnt_reg[k] <= cell_cnt;
                        src_reg[k] <= cell_src;
                        dst_reg[k] <= cell_dst;
                    end else begin
                        cnt_reg[k] <= cnt_reg[(k == 0) ? 0 : k-1];
                        src_reg[k] <= src_reg[(k == 0) ? 0 : k-1];
                        dst_reg[k] <= dst_reg[(k == 0) ? 0 : k-1];
                    end
                end
            end
        end else if (ctrl.shift) begin
            for (int k = 0; k < TOP_ENTRIES; k++) begin
                if (k == TOP_ENTRIES - 1) begin
                    cnt_reg[k] <= '0;
                end else begin
                    cnt_reg[k] <= cnt_reg[(k == TOP_ENTRIES-1) ? k : k+1];
                    src_reg[k] <= src_reg[(k == TOP_ENTRIES-1) ? k : k+1];
                    dst_reg[k] <= dst_reg[(k == TOP_ENTRIES-1) ? k : k+1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            total_reg <= '0;
        end else if (ctrl.clear) begin
            fill_reg  <= '0;
            total_reg <= '0;
        end else if (ctrl.insert) begin
            total_reg <= sum[SUM_W] ? {SUM_W{1'b1}} : sum[SUM_W-1:0];
            if (gt[TOP_ENTRIES-1] && fill_reg < FILL_W'(TOP_ENTRIES)) begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    assign head_src = src_reg[0];
    assign head_dst = dst_reg[0];
    assign head_cnt = cnt_reg[0];
    assign fill     = fill_reg;
    assign total    = total_reg;

endmodule

[rtl/traffic_matrix_top_n.sv]
// Traffic matrix block: counter memory, command sequencer and report emitter.
//
// Input beats carry a command in s_tuser and a source/destination slot pair in
// s_tdata. A count beat does a read-modify-write of one counter (read, then
// saturating write). A slot clear writes zero over the slot's row and column,
// one cell a cycle. A report walks all SLOT_COUNT*SLOT_COUNT cells through one
// compare-and-insert unit, one cell a cycle, zeroing each cell behind the read,
// then emits one beat per ranked entry (or one empty beat) with the grand total.
// The counter memory has a single write port and a single read port. s_tready
// is high only while the sequencer is idle.
// Result beats sit in an output register; while m_tready is low the emitter
// waits, and a count or clear may proceed once the last beat is registered.
// After reset the block zeroes all 2**(2*clog2(SLOT_COUNT)) counter memory cells
// (4096 at the default) and accepts nothing meanwhile.
module traffic_matrix_top_n import tmt_pkg::*; #(
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int TOP_ENTRIES = TOP_ENTRIES_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // source_slot[5:0], dest_slot[11:6], zero fill
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // rank[4:0], top_source[10:5], top_dest[16:11],
                                   // entry_count[48:17], grand_total[80:49], zero fill
    output logic [0:0]  m_tuser,   // entry_valid[0]
    output logic        m_tlast
);

    `include "traffic_matrix_top_n_assert.svh"

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int ADDR_W = 2 * SLOT_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int FILL_W = $clog2(TOP_ENTRIES + 1);
    localparam int CMP_W  = ((SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W) + 1;

    typedef enum logic [2:0] {
        ST_CLEARING, ST_IDLE, ST_CNT_WR, ST_REP_WALK, ST_REP_DRAIN, ST_EMIT, ST_SLOT_CLR
    } state_t;

    state_t                 state_reg;
    logic [ADDR_W-1:0]      clr_addr_reg;
    logic [SLOT_W-1:0]      slot_reg, dst_reg, ws_reg, wd_reg, ps_reg, pd_reg;
    logic                   pv_reg;
    logic [SLOT_W:0]        cc_reg;
    logic [FILL_W-1:0]      emit_reg;
    logic                   m_tvalid_reg, m_tlast_reg, m_tuser_reg;
    logic [87:0]            m_tdata_reg;
    logic [87:0]            beat_data;

    logic [COUNT_BITS-1:0]  mem [DEPTH];
    logic [COUNT_BITS-1:0]  rd_data_reg;
    logic [ADDR_W-1:0]      rd_addr, wr_addr;
    logic [COUNT_BITS-1:0]  wr_data;
    logic                   we;

    logic [SLOT_FIELD_W-1:0] in_src, in_dst;
    logic [SLOT_W-1:0]      in_src_idx, in_dst_idx;
    logic                   src_ok, dst_ok, accept, emit_go, emit_last;
    cmd_t                   in_cmd;
    rk_ctrl_t               rk_ctrl;
    logic [SLOT_W-1:0]      head_src, head_dst;
    logic [COUNT_BITS-1:0]  head_cnt;
    logic [FILL_W-1:0]      fill;
    logic [SUM_W-1:0]       total;

    assign in_src     = s_tdata[5:0];
    assign in_dst     = s_tdata[11:6];
    assign in_cmd     = cmd_t'(s_tuser);
    assign in_src_idx = SLOT_W'(in_src);
    assign in_dst_idx = SLOT_W'(in_dst);
    assign src_ok     = CMP_W'(in_src) < CMP_W'(SLOT_COUNT);
    assign dst_ok     = CMP_W'(in_dst) < CMP_W'(SLOT_COUNT);
    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign emit_go    = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);
    assign emit_last  = (fill == '0) || (emit_reg + 1'b1 == fill);

    always_comb begin
        rd_addr = {in_src_idx, in_dst_idx};
        wr_addr = '0;
        wr_data = '0;
        we      = 1'b0;
        case (state_reg)
            ST_CLEARING: begin
                we      = 1'b1;
                wr_addr = clr_addr_reg;
            end
            ST_CNT_WR: begin
                we      = ~&rd_data_reg;
                wr_addr = {slot_reg, dst_reg};
                wr_data = rd_data_reg + 1'b1;
            end
            ST_REP_WALK, ST_REP_DRAIN: begin
                rd_addr = {ws_reg, wd_reg};
                we      = pv_reg;
                wr_addr = {ps_reg, pd_reg};
            end
            ST_SLOT_CLR: begin
                we      = 1'b1;
                wr_addr = cc_reg[SLOT_W] ? {cc_reg[SLOT_W-1:0], slot_reg}
                                         : {slot_reg, cc_reg[SLOT_W-1:0]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rk_ctrl.clear  = accept && (in_cmd == CMD_REPORT);
    assign rk_ctrl.insert = pv_reg;
    assign rk_ctrl.shift  = emit_go;

    tmt_ranker #(
        .TOP_ENTRIES (TOP_ENTRIES),
        .COUNT_BITS  (COUNT_BITS),
        .SLOT_W      (SLOT_W),
        .FILL_W      (FILL_W)
    ) u_ranker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (rk_ctrl),
        .cell_src (ps_reg),
        .cell_dst (pd_reg),
        .cell_cnt (rd_data_reg),
        .head_src (head_src),
        .head_dst (head_dst),
        .head_cnt (head_cnt),
        .fill     (fill),
        .total    (total)
    );

    // empty list: only the total is carried
    always_comb begin
        beat_data = '0;
        if (fill != '0) begin
            beat_data[4:0]   = RANK_W'(emit_reg);
            beat_data[10:5]  = SLOT_FIELD_W'(head_src);
            beat_data[16:11] = SLOT_FIELD_W'(head_dst);
            beat_data[48:17] = sat32(64'(head_cnt));
        end
        beat_data[80:49] = total;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEARING;
            clr_addr_reg <= '0;
            pv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tready && !emit_go) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEARING: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (&clr_addr_reg) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    slot_reg <= in_src_idx;
                    dst_reg  <= in_dst_idx;
                    ws_reg   <= '0;
                    wd_reg   <= '0;
                    cc_reg   <= '0;
                    if (accept) begin
                        case (in_cmd)
                            CMD_COUNT:  if (src_ok && dst_ok) state_reg <= ST_CNT_WR;
                            CMD_REPORT: state_reg <= ST_REP_WALK;
                            CMD_CLEAR:  if (src_ok) state_reg <= ST_SLOT_CLR;
                            default: ;
                        endcase
                    end
                end
                ST_CNT_WR: begin
                    state_reg <= ST_IDLE;
                end
                ST_REP_WALK: begin
                    pv_reg <= 1'b1;
                    ps_reg <= ws_reg;
                    pd_reg <= wd_reg;
                    if (wd_reg == SLOT_W'(SLOT_COUNT - 1)) begin
                        wd_reg <= '0;
                        if (ws_reg == SLOT_W'(SLOT_COUNT - 1)) begin
                            state_reg <= ST_REP_DRAIN;
                        end else begin
                            ws_reg <= ws_reg + 1'b1;
                        end
                    end else begin
                        wd_reg <= wd_reg + 1'b1;
                    end
                end
                ST_REP_DRAIN: begin
                    pv_reg    <= 1'b0;
                    emit_reg  <= '0;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (emit_go) begin
                        m_tvalid_reg <= 1'b1;
                        m_tlast_reg  <= emit_last;
                        m_tuser_reg  <= (fill != '0);
                        m_tdata_reg  <= beat_data;
                        emit_reg     <= emit_reg + 1'b1;
                        if (emit_last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_SLOT_CLR: begin
                    cc_reg <= cc_reg + 1'b1;
                    if (cc_reg == {1'b1, SLOT_W'(SLOT_COUNT - 1)}) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tlast    = m_tlast_reg;

    `TMT_ASSERT(a_fill_bound, fill <= FILL_W'(TOP_ENTRIES), "ranked fill exceeds list size")
    `TMT_ASSERT(a_empty_is_last, (m_tvalid && !m_tuser[0]) |-> m_tlast, "empty beat not last")
    `TMT_ASSERT_NEXT(a_busy_after_report, accept && (in_cmd == CMD_REPORT), !s_tready, "ready after report")

endmodule

[tb/traffic_matrix_top_n_tb.sv]
// Self-checking testbench for the traffic matrix top-N block.
`timescale 1ns / 1ps

module traffic_matrix_top_n_tb;
    import tmt_pkg::*;

    localparam int SLOTS = 64;
    localparam int TOPN = 20;
    localparam int DIRECTED_ROWS = 14;
    localparam longint CYCLE_LIMIT = 64'd3000000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [4:0]  rank;
        logic [5:0]  src;
        logic [5:0]  dst;
        logic [31:0] cnt;
        logic [31:0] total;
        logic        valid;
        logic        last;
    } entry_t;

    typedef struct {
        logic [1:0] cmd;
        logic [5:0] src;
        logic [5:0] dst;
        int         burst;
        bit         fixed;
        entry_t     want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    logic [31:0] traffic [SLOTS*SLOTS];
    entry_t      expected_entries[$];
    int          errors = 0;
    longint      cycles = 0;
    bit          hold_sink = 1'b0;

    traffic_matrix_top_n DUT (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Apply one command to the shadow matrix; a report pushes its ranked beats.
    task automatic apply_command(input logic [1:0] cmd, input logic [5:0] src,
                                 input logic [5:0] dst);
        logic [5:0]  rs [TOPN];
        logic [5:0]  rd [TOPN];
        logic [31:0] rc [TOPN];
        int          filled;
        int          pos;
        logic [32:0] total;
        logic [31:0] n;
        entry_t      e;
        filled = 0;
        total = '0;
        if (cmd == CMD_COUNT) begin
            if (traffic[{src, dst}] != 32'hFFFF_FFFF)
                traffic[{src, dst}] = traffic[{src, dst}] + 1;
        end else if (cmd == CMD_CLEAR) begin
            for (int i = 0; i < SLOTS; i++) begin
                traffic[{src, 6'(i)}] = '0;
                traffic[{6'(i), src}] = '0;
            end
        end else if (cmd == CMD_REPORT) begin
            for (int k = 0; k < TOPN; k++) begin
                rs[k] = '0; rd[k] = '0; rc[k] = '0;
            end
            for (int c = 0; c < SLOTS*SLOTS; c++) begin
                n = traffic[c];
                total = total + n;
                if (total[32]) total = 33'h0_FFFF_FFFF;
                pos = TOPN;
                while (pos > 0 && n > rc[pos-1]) pos--;
                if (pos < TOPN) begin
                    for (int k = TOPN-1; k > pos; k--) begin
                        rs[k] = rs[k-1]; rd[k] = rd[k-1]; rc[k] = rc[k-1];
                    end
                    rs[pos] = c[11:6]; rd[pos] = c[5:0]; rc[pos] = n;
                    if (filled < TOPN) filled++;
                end
                traffic[c] = '0;
            end
            if (filled == 0) begin
                e = '0;
                e.total = total[31:0];
                e.last = 1'b1;
                expected_entries.push_back(e);
            end
            for (int k = 0; k < filled; k++) begin
                e.rank = 5'(k); e.src = rs[k]; e.dst = rd[k]; e.cnt = rc[k];
                e.total = total[31:0]; e.valid = 1'b1; e.last = (k == filled-1);
                expected_entries.push_back(e);
            end
        end
    endtask

    // Offer one beat and hold it until accepted.
    task automatic send_beat(input logic [1:0] cmd, input logic [5:0] src,
                             input logic [5:0] dst);
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {4'b0, dst, src};
        do @(posedge aclk); while (!s_tready);
        apply_command(cmd, src, dst);
    endtask

    task automatic idle_gap();
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) len = 0;
        if (len > 0) begin
            s_tvalid <= 1'b0;
            repeat (len) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_entries.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int len;
        forever begin
            @(posedge aclk);
            if (hold_sink) begin
                // outlast the report walk so the first beat waits in the output register
                m_tready <= 1'b0;
                repeat (6000) @(posedge aclk);
                hold_sink = 1'b0;
            end
            len = $urandom_range(0, 7);
            if (len < 5) m_tready <= 1'b1;
            else begin
                m_tready <= 1'b0;
                repeat ((len == 7) ? $urandom_range(10, 40) : $urandom_range(1, 3))
                    @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        entry_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[4:0], m_tdata[10:5], m_tdata[16:11], m_tdata[48:17],
                   m_tdata[80:49], m_tuser[0], m_tlast};
            if (expected_entries.size() == 0) begin
                $display("%0t unexpected beat: actual %h", $time, got);
                errors++;
            end else begin
                want = expected_entries.pop_front();
                if (got.rank !== want.rank || got.src !== want.src ||
                    got.dst !== want.dst || got.cnt !== want.cnt ||
                    got.total !== want.total || got.valid !== want.valid ||
                    got.last !== want.last) begin
                    $display("%0t mismatch: expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        end
    end

    initial begin
        row_t dir [DIRECTED_ROWS];
        int   pick;
        int   hot_src, hot_dst;
        for (int c = 0; c < SLOTS*SLOTS; c++) traffic[c] = '0;
        // empty report, counts at corner slots, ties, clears, unknown command
        dir[0]  = '{CMD_REPORT, 6'd0, 6'd0, 1, 1'b1, '{5'd0, 6'd0, 6'd0, 32'd0, 32'd0, 1'b0, 1'b1}};
        dir[1]  = '{CMD_COUNT, 6'd63, 6'd63, 1, 1'b0, '0};
        dir[2]  = '{CMD_REPORT, 6'd0, 6'd0, 1, 1'b1, '{5'd0, 6'd63, 6'd63, 32'd1, 32'd1, 1'b1, 1'b1}};
        dir[3]  = '{CMD_UNUSED, 6'd5, 6'd7, 1, 1'b0, '0};
        dir[4]  = '{CMD_REPORT, 6'd0, 6'd0, 1, 1'b1, '{5'd0, 6'd0, 6'd0, 32'd0, 32'd0, 1'b0, 1'b1}};
        dir[5]  = '{CMD_COUNT, 6'd0, 6'd0, 3, 1'b0, '0};
        dir[6]  = '{CMD_COUNT, 6'd63, 6'd0, 3, 1'b0, '0};
        dir[7]  = '{CMD_COUNT, 6'd0, 6'd63, 5, 1'b0, '0};
        dir[8]  = '{CMD_COUNT, 6'd42, 6'd21, 2, 1'b0, '0};
        dir[9]  = '{CMD_REPORT, 6'd0, 6'd0, 1, 1'b0, '0};
        dir[10] = '{CMD_COUNT, 6'd9, 6'd9, 4, 1'b0, '0};
        dir[11] = '{CMD_CLEAR, 6'd9, 6'd0, 1, 1'b0, '0};
        dir[12] = '{CMD_REPORT, 6'd0, 6'd0, 1, 1'b1, '{5'd0, 6'd0, 6'd0, 32'd0, 32'd0, 1'b0, 1'b1}};
        dir[13] = '{CMD_CLEAR, 6'd63, 6'd0, 1, 1'b0, '0};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir[i]) begin
            for (int b = 0; b < dir[i].burst; b++) begin
                send_beat(dir[i].cmd, dir[i].src, dir[i].dst);
                if (dir[i].fixed && expected_entries.size() > 0)
                    expected_entries[expected_entries.size()-1] = dir[i].want;
            end
            idle_gap();
        end
        drain();

        // Send 30 random count beats, then hold the receiver while a report runs.
        for (int i = 0; i < 30; i++) send_beat(CMD_COUNT, 6'($urandom), 6'($urandom));
        hold_sink = 1'b1;
        send_beat(CMD_REPORT, 6'($urandom), 6'($urandom));
        for (int i = 0; i < 5; i++) send_beat(CMD_COUNT, 6'($urandom), 6'($urandom));
        drain();

        // Random traffic concentrated on a few hot cells so the ranking matters.
        for (int i = 0; i < 170; i++) begin
            hot_src = $urandom_range(0, 7);
            hot_dst = $urandom_range(56, 63);
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_beat(CMD_COUNT, ($urandom_range(0, 1) ? 6'(hot_src) : 6'($urandom)),
                          ($urandom_range(0, 1) ? 6'(hot_dst) : 6'($urandom)));
            else if (pick < 80)
                send_beat(CMD_REPORT, 6'($urandom), 6'($urandom));
            else if (pick < 92)
                send_beat(CMD_CLEAR, 6'($urandom), 6'($urandom));
            else
                send_beat(CMD_UNUSED, 6'($urandom), 6'($urandom));
            idle_gap();
            if (i == 85) drain();
        end
        send_beat(CMD_REPORT, 6'd0, 6'd0);
        drain();

        if (errors == 0 && expected_entries.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

[traffic_matrix_top_n.f]
+incdir+rtl
rtl/tmt_pkg.sv
rtl/tmt_ranker.sv
rtl/traffic_matrix_top_n.sv
tb/traffic_matrix_top_n_tb.sv
